[rtl/mwc_clm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mwc_clm_pkg;

  localparam int unsigned MaxLagBytes = 16;
  localparam int unsigned DigitW      = 8;
  localparam int unsigned StateW      = MaxLagBytes * DigitW;
  localparam int unsigned CarryW      = 16;
  localparam int unsigned CountW      = 64;
  localparam int unsigned InStateW    = 64;
  localparam int unsigned LagW        = 5;
  localparam int unsigned ByteIdxW    = $clog2(MaxLagBytes);
  localparam int unsigned ProdW       = DigitW + CarryW;

  // configuration register indexes
  localparam logic [1:0] CFG_MULTIPLIER = 2'd0;
  localparam logic [1:0] CFG_LAG_BYTES  = 2'd1;
  localparam logic [1:0] CFG_STEP_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    OUTCOME_CLOSED    = 2'd0,
    OUTCOME_BOUND     = 2'd1,
    OUTCOME_NOT_CANON = 2'd2
  } outcome_e;

endpackage

`default_nettype wire

[rtl/mwc_cycle_length_meter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cycle length meter for a multiply-with-carry generator with an 8*lag_bytes bit
// state and a 16-bit carry. Each input transaction (start state, start carry)
// runs one search and yields one result transaction: the step count when the
// cycle closes (outcome 0), the step limit when it is reached first (outcome 1),
// or zero when the pair drops below the start pair (outcome 2). The state is
// processed one byte per cycle through a single 8x16 multiply-add (lag_bytes
// clamped to 1..16); the last byte of a step waits while a stalled result holds
// the output register. The input side stalls while a search runs; a finished
// result waits in the output register while the next transaction is taken.
// Configuration must be written only while idle; the block does not enforce it.
module mwc_cycle_length_meter_unit
  import mwc_clm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CountW-1:0]   cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [InStateW-1:0] start_state_i,
  input  wire logic [CarryW-1:0]   start_carry_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CountW-1:0]        cycle_length_o,
  output logic [1:0]               outcome_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e              state_q, state_d;
  logic [CarryW-1:0]   multiplier_q;
  logic [LagW-1:0]     lag_bytes_q;
  logic [CountW-1:0]   step_limit_q;

  logic [StateW-1:0]   x_q, x_d;
  logic [StateW-1:0]   s_q, s_d;
  logic [CarryW-1:0]   carry_q, carry_d;
  logic [CarryW-1:0]   c0_q, c0_d;
  logic [ByteIdxW-1:0] k_q, k_d;
  logic                lt_q, lt_d;
  logic                ne_q, ne_d;
  logic [CountW-1:0]   p_q, p_d;
  logic                out_valid_q, out_valid_d;
  logic [CountW-1:0]   len_q, len_d;
  outcome_e            outcome_q, outcome_d;

  logic [LagW-1:0]     lag_eff;
  logic [ByteIdxW-1:0] last_idx;
  logic [StateW-1:0]   x_load;
  logic [ProdW-1:0]    prod;
  logic [DigitW-1:0]   nb, sb;
  logic [CarryW-1:0]   c_new;
  logic [CountW-1:0]   p_inc;
  logic                last, out_free, byte_ne, lt_f, ne_f, pair_lt, pair_eq, at_limit;

  always_comb begin
    if (lag_bytes_q == '0) begin
      lag_eff = LagW'(1);
    end else if (lag_bytes_q > LagW'(MaxLagBytes)) begin
      lag_eff = LagW'(MaxLagBytes);
    end else begin
      lag_eff = lag_bytes_q;
    end
  end

  assign last_idx = ByteIdxW'(lag_eff - LagW'(1));

  // mask the start state to the active bytes
  always_comb begin
    logic [StateW-1:0] wide;
    wide = StateW'(start_state_i);
    for (int i = 0; i < MaxLagBytes; i++) begin
      x_load[i*DigitW +: DigitW] = (LagW'(i) < lag_eff) ? wide[i*DigitW +: DigitW]
                                                          : '0;
    end
  end

  // one byte of state times the multiplier plus the running carry
  assign prod    = ProdW'(x_q[DigitW-1:0]) * ProdW'(multiplier_q) + ProdW'(carry_q);
  assign nb      = prod[DigitW-1:0];
  assign sb      = s_q[DigitW-1:0];
  assign c_new   = prod[ProdW-1:DigitW];
  assign byte_ne = (nb != sb);
  assign lt_f    = byte_ne ? (nb < sb) : lt_q;
  assign ne_f    = byte_ne | ne_q;
  assign pair_lt = (c_new != c0_q) ? (c_new < c0_q) : lt_f;
  assign pair_eq = (c_new == c0_q) && !ne_f;
  assign p_inc   = p_q + CountW'(1);
  assign at_limit = (p_inc == step_limit_q) || (step_limit_q == '0);
  assign last    = (k_q == last_idx);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    s_d         = s_q;
    carry_d     = carry_q;
    c0_d        = c0_q;
    k_d         = k_q;
    lt_d        = lt_q;
    ne_d        = ne_q;
    p_d         = p_q;
    out_valid_d = out_valid_q;
    len_d       = len_q;
    outcome_d   = outcome_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d     = x_load;
          s_d     = x_load;
          carry_d = start_carry_i;
          c0_d    = start_carry_i;
          k_d     = '0;
          lt_d    = 1'b0;
          ne_d    = 1'b0;
          p_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last || out_free) begin
          x_d = x_q >> DigitW;
          x_d[{last_idx, 3'b000} +: DigitW] = nb;
          s_d = s_q >> DigitW;
          s_d[{last_idx, 3'b000} +: DigitW] = sb;
          carry_d = c_new;
          lt_d    = lt_f;
          ne_d    = ne_f;
          k_d     = k_q + ByteIdxW'(1);
          if (last) begin
            k_d  = '0;
            lt_d = 1'b0;
            ne_d = 1'b0;
            p_d  = p_inc;
            if (at_limit) begin
              out_valid_d = 1'b1;
              len_d       = step_limit_q;
              outcome_d   = OUTCOME_BOUND;
              state_d     = ST_IDLE;
            end else if (pair_lt) begin
              out_valid_d = 1'b1;
              len_d       = '0;
              outcome_d   = OUTCOME_NOT_CANON;
              state_d     = ST_IDLE;
            end else if (pair_eq) begin
              out_valid_d = 1'b1;
              len_d       = p_inc;
              outcome_d   = OUTCOME_CLOSED;
              state_d     = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      lt_q        <= 1'b0;
      ne_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      lt_q        <= lt_d;
      ne_q        <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    s_q       <= s_d;
    carry_q   <= carry_d;
    c0_q      <= c0_d;
    p_q       <= p_d;
    len_q     <= len_d;
    outcome_q <= outcome_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiplier_q <= CarryW'(1);
      lag_bytes_q  <= LagW'(1);
      step_limit_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MULTIPLIER: multiplier_q <= cfg_data_i[CarryW-1:0];
        CFG_LAG_BYTES:  lag_bytes_q  <= cfg_data_i[LagW-1:0];
        CFG_STEP_LIMIT: step_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cycle_length_o = len_q;
  assign outcome_o      = outcome_q;

endmodule

`default_nettype wire

[rtl/mwc_clm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mwc_clm_checker
  import mwc_clm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [CountW-1:0]   cycle_length_o,
  input wire logic [1:0]          outcome_o
);

  // a taken transaction starts a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("search did not start after input transaction");

  // a new result only ends a running search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a running search");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OUTCOME_CLOSED) || (outcome_o == OUTCOME_BOUND) ||
                    (outcome_o == OUTCOME_NOT_CANON))
    else $error("unknown outcome code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUTCOME_NOT_CANON) |-> (cycle_length_o == '0))
    else $error("not canonical result with nonzero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cycle_length_o) &&
                                   $stable(outcome_o))
    else $error("stalled result changed");

endmodule

bind mwc_cycle_length_meter_unit mwc_clm_checker u_mwc_clm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cycle_length_o (cycle_length_o),
  .outcome_o      (outcome_o)
);

`default_nettype wire

[test/tb_mwc_cycle_length_meter_unit.sv]
`timescale 1ns / 1ps

module tb_mwc_cycle_length_meter_unit;
  import mwc_clm_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;
  localparam longint unsigned CycleLimit = 64'd5_000_000;
  localparam int unsigned ItemCycles = 4096;

  typedef struct packed {
    logic [CountW-1:0] length;
    outcome_e          outcome;
  } search_result_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = CFG_MULTIPLIER;
  logic [CountW-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [InStateW-1:0] start_state_i = '0;
  logic [CarryW-1:0]   start_carry_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CountW-1:0]   cycle_length_o;
  logic [1:0]          outcome_o;

  // shadow copy of the configuration registers
  logic [CarryW-1:0] mwc_mult = 16'd1;
  logic [LagW-1:0]   mwc_lag = 5'd1;
  logic [CountW-1:0] mwc_limit = '1;

  search_result_t  pending_results[$];
  int unsigned     mismatch_count = 0;
  int unsigned     results_checked = 0;
  int unsigned     closed_seen = 0;
  int unsigned     bound_seen = 0;
  int unsigned     noncanon_seen = 0;
  int unsigned     config_count = 0;
  longint unsigned cycle_count = 0;
  int unsigned     hold_cycles_req = 0;
  stall_mode_e     stall_mode = STALL_NONE;

  mwc_cycle_length_meter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_state_i  (start_state_i),
    .start_carry_i  (start_carry_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cycle_length_o (cycle_length_o),
    .outcome_o      (outcome_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned lag_of(input logic [LagW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxLagBytes) return MaxLagBytes;
    return 32'(v);
  endfunction

  function automatic logic [StateW-1:0] state_mask(input int unsigned sbits);
    return {StateW{1'b1}} >> (StateW - sbits);
  endfunction

  // one generator step: low sbits of state*mult+carry become the state, the rest the carry
  function automatic void mwc_advance(inout logic [StateW-1:0] x, inout logic [CarryW-1:0] c,
                                      input int unsigned sbits);
    logic [StateW+CarryW-1:0] t;
    t = {{CarryW{1'b0}}, x} * mwc_mult + c;
    x = t[StateW-1:0] & state_mask(sbits);
    c = CarryW'(t >> sbits);
  endfunction

  // returns 0 when the search runs past max_steps without an outcome
  function automatic bit mwc_search(input logic [InStateW-1:0] st, input logic [CarryW-1:0] cy,
                                    input longint unsigned max_steps,
                                    output search_result_t res);
    int unsigned       sbits;
    logic [StateW-1:0] x, x0;
    logic [CarryW-1:0] c, c0;
    logic [CountW-1:0] steps;
    sbits = lag_of(mwc_lag) * DigitW;
    x0 = {{(StateW-InStateW){1'b0}}, st} & state_mask(sbits);
    c0 = cy;
    x = x0;
    c = c0;
    steps = '0;
    res.length = '0;
    res.outcome = OUTCOME_CLOSED;
    while (steps < max_steps) begin
      mwc_advance(x, c, sbits);
      steps++;
      if (steps >= mwc_limit) begin
        res.length = mwc_limit;
        res.outcome = OUTCOME_BOUND;
        return 1'b1;
      end
      if ({c, x} < {c0, x0}) begin
        res.outcome = OUTCOME_NOT_CANON;
        return 1'b1;
      end
      if ({c, x} == {c0, x0}) begin
        res.length = steps;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // settle onto the cycle, then replace the start with the cycle's lowest pair
  function automatic bit lowest_on_cycle(inout logic [InStateW-1:0] st,
                                         inout logic [CarryW-1:0] cy,
                                         input int unsigned budget);
    int unsigned              sbits;
    logic [StateW-1:0]        x, x0;
    logic [CarryW-1:0]        c, c0;
    logic [CarryW+StateW-1:0] best;
    sbits = lag_of(mwc_lag) * DigitW;
    if (sbits > InStateW) return 1'b0;
    x = {{(StateW-InStateW){1'b0}}, st} & state_mask(sbits);
    c = cy;
    repeat (32) mwc_advance(x, c, sbits);
    x0 = x;
    c0 = c;
    best = {c, x};
    for (int unsigned i = 0; i < budget; i++) begin
      mwc_advance(x, c, sbits);
      if ({c, x} < best) best = {c, x};
      if ({c, x} == {c0, x0}) begin
        st = best[InStateW-1:0];
        cy = best[StateW +: CarryW];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void pick_item(output logic [InStateW-1:0] st,
                                    output logic [CarryW-1:0] cy, input bit try_lowest);
    search_result_t probe;
    int unsigned    budget;
    budget = ItemCycles / lag_of(mwc_lag);
    for (int tries = 0; tries < 40; tries++) begin
      st = {$urandom, $urandom};
      cy = CarryW'($urandom);
      case ($urandom_range(0, 7))
        0: cy = '0;
        1: st = '0;
        2: st = '1;
        3: cy = '1;
        default: ;
      endcase
      if (try_lowest) void'(lowest_on_cycle(st, cy, budget));
      if (mwc_search(st, cy, budget, probe)) return;
    end
    st = '0;
    cy = '0;
  endfunction

  always @(posedge clk_i) begin : result_check
    search_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: length %0d outcome %0d", $time, cycle_length_o,
                 outcome_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (cycle_length_o !== want.length) begin
          $display("%0t: cycle_length mismatch: expected %0d, actual %0d", $time, want.length,
                   cycle_length_o);
          mismatch_count++;
        end
        if (outcome_o !== want.outcome) begin
          $display("%0t: outcome mismatch: expected %0d, actual %0d", $time, want.outcome,
                   outcome_o);
          mismatch_count++;
        end
        case (want.outcome)
          OUTCOME_CLOSED: closed_seen++;
          OUTCOME_BOUND:  bound_seen++;
          default:        noncanon_seen++;
        endcase
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned beat;
    hold_left = 0;
    beat = 0;
    forever begin
      @(posedge clk_i);
      beat++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_cycles_req != 0) begin
        hold_left = hold_cycles_req - 1;
        hold_cycles_req <= 0;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ((beat % 7) < 3);
        endcase
      end
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic idle(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic apply_config(input logic [CarryW-1:0] mult, input logic [LagW-1:0] lag,
                              input logic [CountW-1:0] limit);
    logic [CountW-1:0] word;
    wait_drained();
    word = {$urandom, $urandom};
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSpare;
    cfg_data_i <= word;
    @(posedge clk_i);
    word = {$urandom, $urandom};
    word[CarryW-1:0] = mult;
    cfg_idx_i <= CFG_MULTIPLIER;
    cfg_data_i <= word;
    @(posedge clk_i);
    mwc_mult = mult;
    word = {$urandom, $urandom};
    word[LagW-1:0] = lag;
    cfg_idx_i <= CFG_LAG_BYTES;
    cfg_data_i <= word;
    @(posedge clk_i);
    mwc_lag = lag;
    cfg_idx_i <= CFG_STEP_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    mwc_limit = limit;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    config_count++;
  endtask

  task automatic send_item(input logic [InStateW-1:0] st, input logic [CarryW-1:0] cy);
    search_result_t want;
    void'(mwc_search(st, cy, 64'd1_000_000, want));
    in_valid_i <= 1'b1;
    start_state_i <= st;
    start_carry_i <= cy;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(want);
  endtask

  task automatic test_reset_defaults();
    stall_mode <= STALL_LIGHT;
    send_item(64'd0, 16'd0);
    send_item('1, '1);
    send_item(64'h0123_4567_89ab_cdef, 16'd0);
    send_item(64'h0000_0000_0000_00ff, 16'd1);
    send_item(64'h0000_0000_0000_0080, 16'h8000);
  endtask

  // limit zero reports bound with zero; limit one wins over a closure on the first step
  task automatic test_step_limit_edges();
    apply_config(16'hffff, 5'd31, 64'd0);
    stall_mode <= STALL_HEAVY;
    send_item('1, '1);
    send_item(64'd0, 16'd0);
    apply_config(16'h0000, 5'd0, 64'd1);
    send_item(64'd0, 16'd0);
    send_item(64'h0000_0000_0000_1234, 16'h5678);
  endtask

  task automatic test_zero_multiplier();
    apply_config(16'h0000, 5'd2, 64'd64);
    stall_mode <= STALL_PERIODIC;
    send_item(64'd0, 16'd0);
    send_item(64'd5, 16'd0);
    send_item('1, '1);
  endtask

  task automatic test_lag_extremes();
    apply_config(16'h8001, 5'd16, 64'd100);
    stall_mode <= STALL_LIGHT;
    send_item('1, '1);
    send_item(64'hdead_beef_0000_0001, 16'd0);
    apply_config(16'h7fff, 5'd8, 64'd100);
    send_item('1, 16'd1);
    send_item(64'h8000_0000_0000_0000, 16'h4000);
    apply_config(16'h0003, 5'd17, 64'd150);
    send_item(64'd1, 16'd0);
  endtask

  task automatic test_closed_cycles();
    logic [InStateW-1:0] st;
    logic [CarryW-1:0]   cy;
    for (int k = 0; k < 2; k++) begin
      apply_config(CarryW'($urandom_range(2, 12)), 5'd1,
                   (k == 0) ? {CountW{1'b1}} : CountW'($urandom_range(20, 200)));
      stall_mode <= STALL_PERIODIC;
      for (int n = 0; n < 10; n++) begin
        pick_item(st, cy, 1'b1);
        send_item(st, cy);
      end
    end
  endtask

  // receiver holds off long enough for a finished result and a second search to back up
  task automatic test_output_backpressure();
    logic [InStateW-1:0] st;
    logic [CarryW-1:0]   cy;
    apply_config(16'd3, 5'd1, 64'd40);
    stall_mode <= STALL_NONE;
    hold_cycles_req <= 800;
    for (int n = 0; n < 5; n++) begin
      pick_item(st, cy, 1'b0);
      send_item(st, cy);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [CarryW-1:0]   mult;
    logic [LagW-1:0]     lag;
    logic [CountW-1:0]   limit;
    logic [InStateW-1:0] st;
    logic [CarryW-1:0]   cy;
    int unsigned         burst_left;
    bit                  gaps;
    for (int phase_idx = 0; phase_idx < 7; phase_idx++) begin
      case ($urandom_range(0, 5))
        0:       mult = '0;
        1:       mult = '1;
        2, 3:    mult = CarryW'($urandom_range(1, 40));
        default: mult = CarryW'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       lag = LagW'($urandom_range(17, 31));
        1:       lag = '0;
        2:       lag = LagW'($urandom_range(9, 16));
        default: lag = LagW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       limit = '1;
        1:       limit = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        2:       limit = CountW'($urandom_range(0, 3));
        default: limit = CountW'($urandom_range(4, ItemCycles / lag_of(lag)));
      endcase
      apply_config(mult, lag, limit);
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      gaps = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(1, 6);
      for (int n = 0; n < 15; n++) begin
        pick_item(st, cy, bit'($urandom_range(0, 1)));
        send_item(st, cy);
        burst_left--;
        if (burst_left == 0) begin
          if (gaps) idle($urandom_range(1, 12));
          burst_left = $urandom_range(1, 6);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_step_limit_edges();
    test_zero_multiplier();
    test_lag_extremes();
    test_closed_cycles();
    test_output_backpressure();
    test_random_phases();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("checked %0d searches over %0d register settings", results_checked, config_count);
    $display("outcomes: %0d closed, %0d at step limit, %0d not lowest of cycle", closed_seen,
             bound_seen, noncanon_seen);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
